// File: rtl/ikf_pkg.sv
package ikf_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned REG_FRAC  = 16;
	localparam int unsigned DW        = 32;

	localparam logic [15:0] TIME_STEP_RST = 16'd3277;
	localparam logic [15:0] Q_ANGLE_RST   = 16'd66;
	localparam logic [15:0] Q_BIAS_RST    = 16'd197;
	localparam logic [23:0] R_RST         = 24'd1966;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Q_BIAS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_R         = 2'd3;

	// datapath operations, one per controller step
	typedef enum logic [4:0] {
		OP_NOP,
		OP_RATE,      // rate = sat(gyro - bias)
		OP_M_RATE_DT, // mul rate*dt
		OP_ANGLE_P,   // angle += prod
		OP_M_P11_DT,  // mul p11*dt -> t11
		OP_INNER,     // inner = sat(t11 - p01 - p10 + qa)
		OP_M_INN_DT,  // mul inner*dt
		OP_P00,       // p00 += prod
		OP_P01_P10,   // p01 -= t11, p10 -= t11
		OP_M_QB_DT,   // mul qb*dt
		OP_P11,       // p11 += prod
		OP_DIV0,      // start divide p00/s
		OP_DIV1,      // start divide p10/s
		OP_ERR,       // err = sat(meas - angle)
		OP_M_K0_ERR,
		OP_ANGLE_C,
		OP_M_K1_ERR,
		OP_BIAS_C,
		OP_M_K0_P00,
		OP_C00,
		OP_M_K0_P01,
		OP_C01,
		OP_M_K1_P00,
		OP_C10,
		OP_M_K1_P01,
		OP_C11,
		OP_COMMIT     // load state and result register
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT_MUL,
		ST_WAIT_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic mul_start;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} sts_t;

endpackage

// File: rtl/ikf_if.sv
interface ikf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] measured_angle;
	logic [31:0] gyro_rate;
	modport source (output valid, measured_angle, gyro_rate, input ready);
	modport sink   (input valid, measured_angle, gyro_rate, output ready);
endinterface

interface ikf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] angle_estimate;
	logic [31:0] bias_estimate;
	logic [31:0] unbiased_rate;
	modport source (output valid, angle_estimate, bias_estimate, unbiased_rate, input ready);
	modport sink   (input valid, angle_estimate, bias_estimate, unbiased_rate, output ready);
endinterface

// File: rtl/ikf_div.sv
// Restoring divider, one quotient bit per cycle. Truncates toward zero,
// saturates to 32 bits, zero divisor gives zero.
module ikf_div #(
	parameter int unsigned FRAC = ikf_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [33:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int unsigned NW = 32 + FRAC;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [NW-1:0] qt_q;
	logic [NW:0]   rem_q;
	logic [33:0]   d_q;
	logic          neg_q;
	logic          zero_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [NW:0]   trial;
	logic [NW:0]   sub;
	logic [NW:0]   mag;
	logic signed [NW+1:0] sq;

	assign trial = {rem_q[NW-1:0], n_q[NW-1]};
	assign sub   = trial - {{(NW+1-34){1'b0}}, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= num[31] ? NW'(-{{FRAC{num[31]}}, num} <<< FRAC)
			                  : NW'({{FRAC{1'b0}}, num} << FRAC);
			d_q    <= den[33] ? -den : den;
			neg_q  <= num[31] ^ den[33];
			zero_q <= (den == '0);
			rem_q  <= '0;
			qt_q   <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (!sub[NW]) begin
				rem_q <= sub;
				qt_q  <= {qt_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				qt_q  <= {qt_q[NW-2:0], 1'b0};
			end
		end
	end

	assign mag = {1'b0, qt_q};
	assign sq  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	always_comb begin
		if (zero_q)
			quo = '0;
		else if (sq > (NW+2)'(signed'(32'sh7fffffff)))
			quo = 32'sh7fffffff;
		else if (sq < -(NW+2)'(signed'(33'sh080000000)))
			quo = 32'sh80000000;
		else
			quo = 32'(sq);
	end
endmodule

// File: rtl/ikf_datapath.sv
// Shared registered multiplier, divider, ALU and state registers.
module ikf_datapath #(
	parameter int unsigned FRAC = ikf_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ikf_pkg::cmd_t      cmd,
	output ikf_pkg::sts_t      sts,
	input  logic               load,
	input  logic [31:0]        meas_in,
	input  logic [31:0]        gyro_in,
	input  logic [15:0]        dt,
	input  logic [15:0]        qa,
	input  logic [15:0]        qb,
	input  logic [23:0]        rn,
	output logic [31:0]        angle_out,
	output logic [31:0]        bias_out,
	output logic [31:0]        rate_out
);
	localparam logic signed [35:0] SMAX = 36'sh07fffffff;
	localparam logic signed [35:0] SMIN = -36'sh080000000;

	logic signed [31:0] angle_q, bias_q, c_q [4];
	logic signed [31:0] meas_q, gyro_q, rate_q;
	logic signed [31:0] ang_q, p00_q, p01_q, p10_q, p11_q, t11_q, inner_q;
	logic signed [31:0] k0_q, k1_q, err_q, n00_q, n01_q, n10_q, n11_q, bnew_q;
	logic signed [31:0] ma, mb;
	logic [5:0]         mfrac;
	logic signed [31:0] ma_s1, mb_s1;
	logic [5:0]         mfrac_s1;
	logic signed [63:0] mp_s2;
	logic [5:0]         mfrac_s2;
	logic [1:0]         mv_q;
	logic signed [31:0] prod;
	logic signed [63:0] sh;
	logic signed [31:0] qas, qbs;
	logic signed [33:0] div_den;
	logic signed [31:0] div_num;
	logic               div_done;
	logic signed [31:0] div_quo;
	logic               div1_q;

	function automatic logic signed [31:0] sat(input logic signed [35:0] v);
		if (v > SMAX) return 32'sh7fffffff;
		if (v < SMIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] rscale(input logic [23:0] v);
		logic [55:0] w;
		w = (FRAC >= ikf_pkg::REG_FRAC) ? (56'(v) << (FRAC - ikf_pkg::REG_FRAC))
		                               : (56'(v) >> (ikf_pkg::REG_FRAC - FRAC));
		return w[31:0];
	endfunction

	assign qas = rscale({8'd0, qa});
	assign qbs = rscale({8'd0, qb});

	// operand select
	always_comb begin
		ma = rate_q; mb = $signed({16'd0, dt}); mfrac = 6'(ikf_pkg::REG_FRAC);
		case (cmd.op)
			ikf_pkg::OP_M_RATE_DT: begin ma = rate_q; end
			ikf_pkg::OP_M_P11_DT:  begin ma = p11_q; end
			ikf_pkg::OP_M_INN_DT:  begin ma = inner_q; end
			ikf_pkg::OP_M_QB_DT:   begin ma = qbs; end
			ikf_pkg::OP_M_K0_ERR:  begin ma = k0_q; mb = err_q; mfrac = 6'(FRAC); end
			ikf_pkg::OP_M_K1_ERR:  begin ma = k1_q; mb = err_q; mfrac = 6'(FRAC); end
			ikf_pkg::OP_M_K0_P00:  begin ma = k0_q; mb = p00_q; mfrac = 6'(FRAC); end
			ikf_pkg::OP_M_K0_P01:  begin ma = k0_q; mb = p01_q; mfrac = 6'(FRAC); end
			ikf_pkg::OP_M_K1_P00:  begin ma = k1_q; mb = p00_q; mfrac = 6'(FRAC); end
			ikf_pkg::OP_M_K1_P01:  begin ma = k1_q; mb = p01_q; mfrac = 6'(FRAC); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ma_s1 <= ma; mb_s1 <= mb; mfrac_s1 <= mfrac;
		end
		mp_s2    <= ma_s1 * mb_s1;
		mfrac_s2 <= mfrac_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mv_q <= '0;
		else         mv_q <= {mv_q[0], cmd.mul_start};
	end

	assign sh   = mp_s2 >>> mfrac_s2;
	assign prod = (sh > 64'sh7fffffff) ? 32'sh7fffffff :
	              (sh < -64'sh80000000) ? 32'sh80000000 : sh[31:0];
	assign sts.mul_done = mv_q[1];

	// R is unsigned; it may fill all 32 bits at large fraction counts
	assign div_den = 34'(p00_q) + {2'b00, rscale(rn)};
	assign div_num = (cmd.op == ikf_pkg::OP_DIV1) ? p10_q : p00_q;

	ikf_div #(.FRAC(FRAC)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);
	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0; bias_q <= '0;
			for (int i = 0; i < 4; i++) c_q[i] <= '0;
			div1_q <= 1'b0;
		end else begin
			if (cmd.div_start) div1_q <= (cmd.op == ikf_pkg::OP_DIV1);
			if (cmd.op == ikf_pkg::OP_COMMIT) begin
				angle_q <= ang_q; bias_q <= bnew_q;
				c_q[0] <= n00_q; c_q[1] <= n01_q; c_q[2] <= n10_q; c_q[3] <= n11_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			meas_q <= meas_in; gyro_q <= gyro_in;
			ang_q <= angle_q;
			p00_q <= c_q[0]; p01_q <= c_q[1]; p10_q <= c_q[2]; p11_q <= c_q[3];
		end
		if (div_done) begin
			if (div1_q) k1_q <= div_quo;
			else        k0_q <= div_quo;
		end
		case (cmd.op)
			ikf_pkg::OP_RATE:    rate_q <= sat(36'(gyro_q) - 36'(bias_q));
			ikf_pkg::OP_ANGLE_P: ang_q <= sat(36'(ang_q) + 36'(prod));
			ikf_pkg::OP_INNER:
				inner_q <= sat(36'(t11_q) - 36'(p01_q) - 36'(p10_q) + 36'(qas));
			ikf_pkg::OP_P00:     p00_q <= sat(36'(p00_q) + 36'(prod));
			ikf_pkg::OP_P01_P10: begin
				p01_q <= sat(36'(p01_q) - 36'(t11_q));
				p10_q <= sat(36'(p10_q) - 36'(t11_q));
			end
			ikf_pkg::OP_P11:     p11_q <= sat(36'(p11_q) + 36'(prod));
			ikf_pkg::OP_ERR:     err_q <= sat(36'(meas_q) - 36'(ang_q));
			ikf_pkg::OP_ANGLE_C: ang_q <= sat(36'(ang_q) + 36'(prod));
			ikf_pkg::OP_BIAS_C:  bnew_q <= sat(36'(bias_q) + 36'(prod));
			ikf_pkg::OP_C00:     n00_q <= sat(36'(p00_q) - 36'(prod));
			ikf_pkg::OP_C01:     n01_q <= sat(36'(p01_q) - 36'(prod));
			ikf_pkg::OP_C10:     n10_q <= sat(36'(p10_q) - 36'(prod));
			ikf_pkg::OP_C11:     n11_q <= sat(36'(p11_q) - 36'(prod));
			default: ;
		endcase
		// p11*dt lands while the controller waits in OP_M_P11_DT
		if (cmd.op == ikf_pkg::OP_M_P11_DT && sts.mul_done) t11_q <= prod;
	end

	assign angle_out = angle_q;
	assign bias_out  = bias_q;
	assign rate_out  = rate_q;
endmodule

// File: rtl/ikf_ctrl.sv
// Step sequencer: walks the op list, waits on multiplier and divider.
module ikf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          load,
	output ikf_pkg::cmd_t cmd,
	input  ikf_pkg::sts_t sts
);
	ikf_pkg::state_t st_q, st_d;
	ikf_pkg::op_t    op_q, op_d;
	logic            is_mul, is_div;

	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		case (op_q)
			ikf_pkg::OP_M_RATE_DT, ikf_pkg::OP_M_P11_DT, ikf_pkg::OP_M_INN_DT,
			ikf_pkg::OP_M_QB_DT, ikf_pkg::OP_M_K0_ERR, ikf_pkg::OP_M_K1_ERR,
			ikf_pkg::OP_M_K0_P00, ikf_pkg::OP_M_K0_P01, ikf_pkg::OP_M_K1_P00,
			ikf_pkg::OP_M_K1_P01: is_mul = 1'b1;
			ikf_pkg::OP_DIV0, ikf_pkg::OP_DIV1: is_div = 1'b1;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		op_d = op_q;
		case (st_q)
			ikf_pkg::ST_IDLE: if (in_valid) begin
				st_d = ikf_pkg::ST_RUN; op_d = ikf_pkg::OP_RATE;
			end
			ikf_pkg::ST_RUN: begin
				if (is_mul)      st_d = ikf_pkg::ST_WAIT_MUL;
				else if (is_div) st_d = ikf_pkg::ST_WAIT_DIV;
				else if (op_q == ikf_pkg::OP_COMMIT) st_d = ikf_pkg::ST_OUT;
				else op_d = ikf_pkg::op_t'(op_q + 1'b1);
			end
			ikf_pkg::ST_WAIT_MUL: if (sts.mul_done) begin
				st_d = ikf_pkg::ST_RUN; op_d = ikf_pkg::op_t'(op_q + 1'b1);
			end
			ikf_pkg::ST_WAIT_DIV: if (sts.div_done) begin
				st_d = ikf_pkg::ST_RUN; op_d = ikf_pkg::op_t'(op_q + 1'b1);
			end
			ikf_pkg::ST_OUT: if (out_ready) st_d = ikf_pkg::ST_IDLE;
			default: st_d = ikf_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (st_q == ikf_pkg::ST_IDLE);
		out_valid = (st_q == ikf_pkg::ST_OUT);
		load      = in_ready && in_valid;
		cmd.op        = (st_q == ikf_pkg::ST_IDLE || st_q == ikf_pkg::ST_OUT)
		                ? ikf_pkg::OP_NOP : op_q;
		cmd.mul_start = (st_q == ikf_pkg::ST_RUN) && is_mul;
		cmd.div_start = (st_q == ikf_pkg::ST_RUN) && is_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ikf_pkg::ST_IDLE;
			op_q <= ikf_pkg::OP_NOP;
		end else begin
			st_q <= st_d;
			op_q <= op_d;
		end
	end
endmodule

// File: rtl/imu_angle_kalman_filter_core.sv
// From input transfer to result valid the core runs 14 plain steps, ten
// shared-multiplier passes and two serial gain divisions (start,
// 32+FRAC_BITS quotient bits, done).
// One item in flight: a new input is taken only once the previous result
// has been taken.
// Reset: arst_n clears angle, bias, covariance and loads register defaults.
module imu_angle_kalman_filter_core #(
	parameter int unsigned FRAC_BITS = ikf_pkg::FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	ikf_in_if.sink      in_ch,
	ikf_out_if.source   out_ch,
	input  logic                           cfg_we,
	input  logic [ikf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ikf_pkg::CFG_DATA_W-1:0] cfg_data
);
	// configuration registers
	logic [15:0] dt_q, qa_q, qb_q;
	logic [23:0] r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= ikf_pkg::TIME_STEP_RST;
			qa_q <= ikf_pkg::Q_ANGLE_RST;
			qb_q <= ikf_pkg::Q_BIAS_RST;
			r_q  <= ikf_pkg::R_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ikf_pkg::REG_TIME_STEP: dt_q <= cfg_data[15:0];
				ikf_pkg::REG_Q_ANGLE:   qa_q <= cfg_data[15:0];
				ikf_pkg::REG_Q_BIAS:    qb_q <= cfg_data[15:0];
				ikf_pkg::REG_R:         r_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ikf_pkg::cmd_t cmd;
	ikf_pkg::sts_t sts;
	logic          load;

	// sequencer
	ikf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.load(load), .cmd(cmd), .sts(sts)
	);

	// arithmetic and filter state; outputs hold during the result transfer
	ikf_datapath #(.FRAC(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .load(load),
		.meas_in(in_ch.measured_angle), .gyro_in(in_ch.gyro_rate),
		.dt(dt_q), .qa(qa_q), .qb(qb_q), .rn(r_q),
		.angle_out(out_ch.angle_estimate), .bias_out(out_ch.bias_estimate),
		.rate_out(out_ch.unbiased_rate)
	);
endmodule
